@@ rtl/tape_block_biphase_encoder_core_defines.svh @@
// assertion macros for the cassette block encoder checks
`ifndef TAPE_BLOCK_BIPHASE_ENCODER_CORE_DEFINES_SVH
`define TAPE_BLOCK_BIPHASE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TBE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TBE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tbe_pkg.sv @@
// shared types, framing constants and the biphase-mark encode function
package tbe_pkg;

	localparam int BLOCK_BYTES = 256;
	localparam int POS_W = $clog2(BLOCK_BYTES + 1);

	localparam int LEADER_BYTES = 32;
	localparam int SYNC_BYTES = 3;
	localparam logic [7:0] LEADER_CODE = 8'h00;
	localparam logic [7:0] SYNC_CODE = 8'h16;
	localparam logic [7:0] STX_CODE = 8'h02;
	localparam logic [7:0] ETX_CODE = 8'h03;

	// byte slots of one sequence, preamble through checksum
	localparam int IDX_LEADER = 0;
	localparam int IDX_SYNC = IDX_LEADER + LEADER_BYTES;
	localparam int IDX_STX = IDX_SYNC + SYNC_BYTES;
	localparam int IDX_DATA = IDX_STX + 1;
	localparam int IDX_ETX = IDX_DATA + 1;
	localparam int IDX_CSUM_LO = IDX_ETX + 1;
	localparam int IDX_CSUM_HI = IDX_CSUM_LO + 1;
	localparam int STEP_W = $clog2(IDX_CSUM_HI + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] csum;
	} cmd_t;

	typedef struct packed {
		logic [15:0] cells;
		logic [7:0]  byte_val;
		logic        run_end;
		logic        block_end;
	} res_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// returns {new line level, 16 half-cell levels}
	function automatic logic [16:0] biphase_encode(input logic level, input logic [7:0] val);
		logic       lvl;
		logic [15:0] cells;
		lvl = level;
		cells = '0;
		for (int i = 0; i < 8; i++) begin
			lvl = ~lvl;
			cells[2*i] = lvl;
			if (val[i]) begin
				lvl = ~lvl;
			end
			cells[2*i+1] = lvl;
		end
		return {lvl, cells};
	endfunction

endpackage

@@ rtl/tape_block_biphase_encoder_core.sv @@
// top level of the cassette block encoder with biphase-mark line coding
//
//  channel   handshake        payload
//  input     push / full      data_byte
//  result    pop / empty      half_cells, sent_byte, run_end, block_end
//
// the back sequencer emits one framed byte per cycle unless its command queue
// is empty or its result queue full: a middle payload word gives 1 byte, a
// block's first word 37 (preamble), its last 4 (etx, checksum); 256 words 295.
// input is taken while the two-entry command queue has room, results leave
// through a two-entry result queue, so either side may stall on its own.
// arst_n clears position, checksum, queues and sets the line level high.
module tape_block_biphase_encoder_core
	import tbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] half_cells,
	output logic [7:0]  sent_byte,
	output logic        run_end,
	output logic        block_end
);

	logic    accept;
	cmd_t    front_cmd;
	cmd_t    head_cmd;
	q_stat_t cmd_stat;
	logic    cmd_pop;
	res_t    res;

	assign full = cmd_stat.full;
	assign accept = push && !cmd_stat.full;

	tbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.cmd       (front_cmd)
	);

	tbe_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_cmd (front_cmd),
		.rd_en  (cmd_pop),
		.rd_cmd (head_cmd),
		.stat   (cmd_stat)
	);

	tbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_stat  (cmd_stat),
		.cmd_pop   (cmd_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	assign half_cells = res.cells;
	assign sent_byte = res.byte_val;
	assign run_end = res.run_end;
	assign block_end = res.block_end;

endmodule

@@ rtl/tbe_front.sv @@
// front: tracks block position and checksum, builds one command per word
module tbe_front
	import tbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	output cmd_t       cmd
);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic [15:0]      sum_base;
	logic [15:0]      sum_new;
	logic             first;
	logic             last;

	assign first = (pos_q == '0);
	assign last = (pos_q == POS_W'(BLOCK_BYTES - 1));
	assign sum_base = first ? 16'd0 : sum_q;
	assign sum_new = sum_base + {8'd0, data_byte};

	always_comb begin
		cmd.data = data_byte;
		cmd.first = first;
		cmd.last = last;
		cmd.csum = sum_new + {8'd0, ETX_CODE};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : pos_q + POS_W'(1);
			sum_q <= sum_new;
		end
	end

endmodule

@@ rtl/tbe_cmd_queue.sv @@
// short command queue between front and back
module tbe_cmd_queue
	import tbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  cmd_t    wr_cmd,
	input  logic    rd_en,
	output cmd_t    rd_cmd,
	output q_stat_t stat
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/tbe_back.sv @@
// back: steps through the framed bytes of a command and biphase-encodes them
module tbe_back
	import tbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  q_stat_t cmd_stat,
	output logic    cmd_pop,
	input  logic    res_pop,
	output logic    res_empty,
	output res_t    res
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              level_q;
	res_t              oq_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] oq_wr_q;
	logic [QPTR_W-1:0] oq_rd_q;
	logic [QCNT_W-1:0] oq_cnt_q;

	logic [STEP_W-1:0] start_idx;
	logic [STEP_W-1:0] end_idx;
	logic [STEP_W-1:0] cur_idx;
	logic [7:0]        cur_byte;
	logic [16:0]       enc;
	logic              emit;
	logic              done;
	logic              oq_pop;
	res_t              new_res;

	assign start_idx = cmd.first ? STEP_W'(IDX_LEADER) : STEP_W'(IDX_DATA);
	assign end_idx = cmd.last ? STEP_W'(IDX_CSUM_HI) : STEP_W'(IDX_DATA);
	assign cur_idx = busy_q ? step_q : start_idx;

	always_comb begin
		if (cur_idx < STEP_W'(IDX_SYNC)) begin
			cur_byte = LEADER_CODE;
		end else if (cur_idx < STEP_W'(IDX_STX)) begin
			cur_byte = SYNC_CODE;
		end else if (cur_idx == STEP_W'(IDX_STX)) begin
			cur_byte = STX_CODE;
		end else if (cur_idx == STEP_W'(IDX_DATA)) begin
			cur_byte = cmd.data;
		end else if (cur_idx == STEP_W'(IDX_ETX)) begin
			cur_byte = ETX_CODE;
		end else if (cur_idx == STEP_W'(IDX_CSUM_LO)) begin
			cur_byte = cmd.csum[7:0];
		end else begin
			cur_byte = cmd.csum[15:8];
		end
	end

	assign enc = biphase_encode(level_q, cur_byte);
	assign emit = !cmd_stat.empty && (oq_cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign done = (cur_idx == end_idx);
	assign cmd_pop = emit && done;

	always_comb begin
		new_res.cells = enc[15:0];
		new_res.byte_val = cur_byte;
		new_res.run_end = done;
		new_res.block_end = (cur_idx == STEP_W'(IDX_CSUM_HI));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			level_q <= 1'b1;
		end else if (emit) begin
			busy_q <= !done;
			step_q <= cur_idx + STEP_W'(1);
			level_q <= enc[16];
		end
	end

	// result queue lets the sequencer keep going while a word waits
	assign res_empty = (oq_cnt_q == '0);
	assign oq_pop = res_pop && !res_empty;
	assign res = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			oq_q[oq_wr_q] <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (emit) begin
				oq_wr_q <= oq_wr_q + QPTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + QPTR_W'(1);
			end
			case ({emit, oq_pop})
				2'b10: oq_cnt_q <= oq_cnt_q + QCNT_W'(1);
				2'b01: oq_cnt_q <= oq_cnt_q - QCNT_W'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/tbe_checker.sv @@
// port-level checks of the encoder output, bound to the top level
`include "tape_block_biphase_encoder_core_defines.svh"

module tbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] half_cells,
	input logic [7:0]  sent_byte,
	input logic        run_end,
	input logic        block_end
);

	logic       last_level_q;
	logic [7:0] mid_flip;

	// a mid-cell flip marks a one
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mid_flip[i] = half_cells[2*i] ^ half_cells[2*i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
		end else if (pop && !empty) begin
			last_level_q <= half_cells[15];
		end
	end

	`TBE_ASSERT_IMP(a_block_end_ends_run, !empty && block_end, run_end, "block end without run end")
	`TBE_ASSERT_IMP(a_cells_match_byte, !empty, mid_flip == sent_byte, "half-cells do not code the byte")
	`TBE_ASSERT_IMP(a_cell_edge_flip, pop && !empty, half_cells[0] != last_level_q, "no flip at cell start")
	`TBE_ASSERT_NXT(a_stall_holds, !empty && !pop, !empty && $stable(sent_byte) && $stable(half_cells), "result changed while stalled")

endmodule

bind tape_block_biphase_encoder_core tbe_checker u_tbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.half_cells (half_cells),
	.sent_byte  (sent_byte),
	.run_end    (run_end),
	.block_end  (block_end)
);

@@ test/testbench.sv @@
// testbench for the cassette block encoder: framing, checksum and biphase-mark levels
`timescale 1ns / 1ps

module testbench;
	import tbe_pkg::*;

	localparam int TOTAL_WORDS = 260;
	localparam int DIRECTED_WORDS = 16;
	localparam int MAX_REPORTS = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop;
	logic [15:0] half_cells;
	logic [7:0]  sent_byte;
	logic        run_end;
	logic        block_end;

	int gap_pct = 0;
	int stall_pct = 0;

	// predicts the framed words of each payload word and checks them in order
	class tape_frame_board;
		logic        line_lvl;
		int unsigned pos;
		logic [15:0] sum;
		res_t        frames[$];
		int          errors;

		function new();
			line_lvl = 1'b1;
			pos = 0;
			sum = '0;
			errors = 0;
		endfunction

		// biphase-mark: flip at every cell start, flip again mid-cell for a one
		function void add_frame(logic [7:0] value, logic last_f, logic block_f);
			res_t r;
			r.cells = '0;
			for (int i = 0; i < 8; i++) begin
				line_lvl = ~line_lvl;
				r.cells[2*i] = line_lvl;
				line_lvl = line_lvl ^ value[i];
				r.cells[2*i+1] = line_lvl;
			end
			r.byte_val = value;
			r.run_end = last_f;
			r.block_end = block_f;
			frames.push_back(r);
		endfunction

		function void note_word(logic [7:0] value);
			logic        closing;
			logic [15:0] csum;
			closing = (pos + 1 >= BLOCK_BYTES);
			if (pos == 0) begin
				sum = '0;
				for (int i = 0; i < LEADER_BYTES; i++)
					add_frame(LEADER_CODE, 1'b0, 1'b0);
				for (int i = 0; i < SYNC_BYTES; i++)
					add_frame(SYNC_CODE, 1'b0, 1'b0);
				add_frame(STX_CODE, 1'b0, 1'b0);
			end
			add_frame(value, !closing, 1'b0);
			sum = sum + 16'(value);
			if (closing) begin
				csum = sum + 16'(ETX_CODE);
				add_frame(ETX_CODE, 1'b0, 1'b0);
				add_frame(csum[7:0], 1'b0, 1'b0);
				add_frame(csum[15:8], 1'b1, 1'b1);
				pos = 0;
			end else begin
				pos++;
			end
		endfunction

		task report_mismatch(string msg);
			if (errors < MAX_REPORTS)
				$display("tb: mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [15:0] cells, logic [7:0] value, logic re, logic be);
			res_t want;
			if (frames.size() == 0) begin
				report_mismatch($sformatf("unexpected word sent_byte=%h", value));
				return;
			end
			want = frames.pop_front();
			if (cells !== want.cells)
				report_mismatch($sformatf("half_cells %h, want %h", cells, want.cells));
			if (value !== want.byte_val)
				report_mismatch($sformatf("sent_byte %h, want %h", value, want.byte_val));
			if (re !== want.run_end)
				report_mismatch($sformatf("run_end %b, want %b", re, want.run_end));
			if (be !== want.block_end)
				report_mismatch($sformatf("block_end %b, want %b", be, want.block_end));
		endtask

		function int pending();
			return frames.size();
		endfunction
	endclass

	tape_frame_board board = new();

	tape_block_biphase_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.empty(empty),
		.pop(pop),
		.half_cells(half_cells),
		.sent_byte(sent_byte),
		.run_end(run_end),
		.block_end(block_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task send_word(logic [7:0] value);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			data_byte <= 8'($urandom_range(255));
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_word(value);
	endtask

	// result side: check what was on the ports before the edge, then pick pop
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				board.check_word(half_cells, sent_byte, run_end, block_end);
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		logic [7:0] directed [DIRECTED_WORDS];
		logic [7:0] value;
		directed = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'hfe, 8'h7f,
			8'h0f, 8'hf0, 8'h33, 8'hcc, 8'h16, 8'h02, 8'h03, 8'hff};
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int idx = 0; idx < TOTAL_WORDS; idx++) begin
			// idling phases; the block start falls in the first, the block end in the last
			case (idx * 4 / TOTAL_WORDS)
				0: begin
					gap_pct = 33;
					stall_pct = 33;
				end
				1: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 68;
					stall_pct = 0;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 68;
				end
			endcase
			if (idx < DIRECTED_WORDS)
				value = directed[idx];
			else if ($urandom_range(7) == 0)
				value = $urandom_range(1) ? 8'hff : 8'h00;
			else
				value = 8'($urandom_range(255));
			send_word(value);
		end
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tbe_pkg.sv
rtl/tbe_front.sv
rtl/tbe_cmd_queue.sv
rtl/tbe_back.sv
rtl/tape_block_biphase_encoder_core.sv
rtl/tbe_checker.sv
test/testbench.sv
